>>> rtl/core/csea_pkg.sv
package csea_pkg;

    // Frame size limits of the line store and the position counters.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Pixel layout: three 8-bit channels, red in the top byte.
    localparam int CHAN_W = 8;
    localparam int N_CHAN = 3;
    localparam int PIX_W  = CHAN_W * N_CHAN;

    // Sum of three channel values, and of three absolute channel differences.
    localparam int SUM_W = CHAN_W + 2;

    // Configuration registers.
    localparam int DIM_W      = 12;
    localparam int THR_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int EXT_W      = DIM_W + 1;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH    = 12'd640;
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT   = 12'd480;
    localparam logic [THR_W-1:0] RESET_EDGE_THRESHOLD = 9'd38;

    // Smallest frame side that has interior pixels.
    localparam int MIN_SIDE = 3;

    // Division by three of a value below 768: (x * 683) >> 11.
    localparam int                 DIV3_SHIFT = 11;
    localparam int                 PROD_W     = SUM_W + DIV3_SHIFT - 1;
    localparam logic [SUM_W-1:0]   DIV3_MUL   = 10'd683;

    // Stream payloads.
    localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_BITS   = COL_W + ROW_W + PIX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Result queue in front of the master side.
    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Five-tap cross around the pixel being filtered.
    typedef struct packed {
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] n;
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] e;
        logic [PIX_W-1:0] w;
    } csea_taps_t;

endpackage

>>> rtl/core/csea_ram.sv
module csea_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry written in the same cycle returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/csea_filter.sv
module csea_filter (
    input  logic                            clk,
    input  csea_pkg::csea_taps_t            taps,
    input  logic [csea_pkg::THR_W-1:0]      threshold,
    output logic [csea_pkg::PIX_W-1:0]      pixel
);

    logic [csea_pkg::CHAN_W-1:0] spread_next;
    logic [csea_pkg::SUM_W-1:0]  gew_next;
    logic [csea_pkg::SUM_W-1:0]  gns_next;

    logic [csea_pkg::CHAN_W-1:0] spread_reg;
    logic [csea_pkg::SUM_W-1:0]  gew_reg;
    logic [csea_pkg::SUM_W-1:0]  gns_reg;
    csea_pkg::csea_taps_t        taps_reg;

    logic [csea_pkg::CHAN_W-1:0] v    [5];
    logic [csea_pkg::CHAN_W-1:0] hi   [csea_pkg::N_CHAN];
    logic [csea_pkg::CHAN_W-1:0] lo   [csea_pkg::N_CHAN];
    logic [csea_pkg::CHAN_W-1:0] span [csea_pkg::N_CHAN];

    logic                        is_edge;
    logic                        across_ew;
    logic [csea_pkg::PIX_W-1:0]  t1;
    logic [csea_pkg::PIX_W-1:0]  t2;
    logic [csea_pkg::SUM_W-1:0]  chan_sum  [csea_pkg::N_CHAN];
    logic [csea_pkg::PROD_W-1:0] chan_prod [csea_pkg::N_CHAN];
    logic [csea_pkg::PIX_W-1:0]  blended;

    function automatic logic [csea_pkg::CHAN_W-1:0] abs_diff(
        input logic [csea_pkg::CHAN_W-1:0] a,
        input logic [csea_pkg::CHAN_W-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    // First stage: per-channel spread over the cross and the two gradient sums.
    always_comb
    begin
        spread_next = '0;
        gew_next    = '0;
        gns_next    = '0;
        for (int ch = 0; ch < csea_pkg::N_CHAN; ch++)
        begin
            v[0] = taps.m[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W];
            v[1] = taps.n[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W];
            v[2] = taps.s[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W];
            v[3] = taps.e[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W];
            v[4] = taps.w[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W];
            hi[ch] = v[0];
            lo[ch] = v[0];
            for (int i = 1; i < 5; i++)
            begin
                if (v[i] > hi[ch])
                begin
                    hi[ch] = v[i];
                end
                if (v[i] < lo[ch])
                begin
                    lo[ch] = v[i];
                end
            end
            span[ch] = hi[ch] - lo[ch];
            if (span[ch] > spread_next)
            begin
                spread_next = span[ch];
            end
            gew_next = gew_next + csea_pkg::SUM_W'(abs_diff(v[3], v[4]));
            gns_next = gns_next + csea_pkg::SUM_W'(abs_diff(v[1], v[2]));
        end
    end

    always_ff @(posedge clk)
    begin
        spread_reg <= spread_next;
        gew_reg    <= gew_next;
        gns_reg    <= gns_next;
        taps_reg   <= taps;
    end

    // Second stage: edge decision and the three-pixel average across the edge.
    always_comb
    begin
        is_edge   = ({1'b0, spread_reg} >= threshold);
        across_ew = (gew_reg >= gns_reg);
        t1        = across_ew ? taps_reg.e : taps_reg.n;
        t2        = across_ew ? taps_reg.w : taps_reg.s;
        for (int ch = 0; ch < csea_pkg::N_CHAN; ch++)
        begin
            chan_sum[ch] =
                csea_pkg::SUM_W'(taps_reg.m[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W])
                + csea_pkg::SUM_W'(t1[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W])
                + csea_pkg::SUM_W'(t2[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W]);
            chan_prod[ch] = csea_pkg::PROD_W'(chan_sum[ch])
                            * csea_pkg::PROD_W'(csea_pkg::DIV3_MUL);
            blended[ch*csea_pkg::CHAN_W +: csea_pkg::CHAN_W] =
                chan_prod[ch][csea_pkg::DIV3_SHIFT +: csea_pkg::CHAN_W];
        end
        pixel = is_edge ? blended : taps_reg.m;
    end

endmodule

>>> rtl/core/cross_stencil_edge_antialias.sv
// Edge anti-aliasing filter for an RGB pixel stream in raster order. One pixel is
// accepted per clock while the result queue has room; each pixel gives up to two
// result items: first the interior pixel one row up and one column left once its
// five-tap cross is complete (blended across any edge found), then the pixel
// itself, unchanged, if it lies on the frame border. Every result carries its
// column and row, and tlast marks the last result caused by an input item. A
// result passes the line store read, spread and gradient stage and blend stage on
// its way to the master side. The sustained rate is one item per clock while
// results drain at least as fast as they are made; on the last row and last column
// each item from the third column or row on gives two results, so there the single
// output beat per cycle sets the pace and the eight-entry result queue throttles
// tready. The two rows above the current one sit in one 2048 x 48-bit
// single-port-write RAM that keeps both row parities of a column in one word,
// read and written back once per item. The RAM is not cleared after reset; the
// first two rows of a frame refill it before any of it is used. Width, height and
// threshold must be written only while the block is idle, which is not enforced.
module cross_stencil_edge_antialias (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csea_pkg::IN_DATA_W-1:0]       s_tdata,   // pixel_in
    input  logic                                 s_tuser,   // frame_start

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csea_pkg::OUT_DATA_W-1:0]      m_tdata,   // out_col, out_row, pixel_out
    output logic                                 m_tlast,   // last_of_item

    input  logic                                 cfg_we,
    input  logic [csea_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [csea_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef struct packed {
        logic [csea_pkg::COL_W-1:0] col;
        logic [csea_pkg::ROW_W-1:0] row;
        logic [csea_pkg::PIX_W-1:0] pix;
        logic                       last;
    } result_t;

    // Configuration.
    logic [csea_pkg::DIM_W-1:0] frame_width_reg;
    logic [csea_pkg::DIM_W-1:0] frame_height_reg;
    logic [csea_pkg::THR_W-1:0] edge_threshold_reg;

    // Position of the next pixel.
    logic [csea_pkg::COL_W-1:0] col_count_reg;
    logic [csea_pkg::ROW_W-1:0] row_count_reg;
    logic [csea_pkg::COL_W-1:0] col_count_next;
    logic [csea_pkg::ROW_W-1:0] row_count_next;

    // Accept stage.
    logic                       accept;
    logic [csea_pkg::DIM_W-1:0] w_eff;
    logic [csea_pkg::DIM_W-1:0] h_eff;
    logic [csea_pkg::COL_W-1:0] col_start;
    logic [csea_pkg::ROW_W-1:0] row_start;
    logic [csea_pkg::COL_W-1:0] col_cur;
    logic [csea_pkg::ROW_W-1:0] row_cur;
    logic                       col_last;
    logic                       row_last;
    logic                       small_frame;
    logic                       is_border;
    logic                       is_interior;

    // Line store stage.
    logic                         s1_valid_reg;
    logic [csea_pkg::COL_W-1:0]   s1_col_reg;
    logic [csea_pkg::ROW_W-1:0]   s1_row_reg;
    logic [csea_pkg::PIX_W-1:0]   s1_pix_reg;
    logic                         s1_filt_reg;
    logic                         s1_border_reg;

    logic [2*csea_pkg::PIX_W-1:0] store_rdata;
    logic [2*csea_pkg::PIX_W-1:0] store_wdata;
    logic [2*csea_pkg::PIX_W-1:0] line_word;
    logic                         fwd_valid_reg;
    logic [csea_pkg::COL_W-1:0]   fwd_addr_reg;
    logic [2*csea_pkg::PIX_W-1:0] fwd_data_reg;
    logic [csea_pkg::PIX_W-1:0]   east_pix;
    logic [csea_pkg::PIX_W-1:0]   up2_pix;

    logic [csea_pkg::PIX_W-1:0]   left_pixel_reg;
    logic [csea_pkg::PIX_W-1:0]   above_center_reg;
    logic [csea_pkg::PIX_W-1:0]   above_west_reg;
    logic [csea_pkg::PIX_W-1:0]   above_north_reg;

    csea_pkg::csea_taps_t         taps;

    // Blend stage.
    logic                         s2_valid_reg;
    logic [csea_pkg::COL_W-1:0]   s2_col_reg;
    logic [csea_pkg::ROW_W-1:0]   s2_row_reg;
    logic [csea_pkg::PIX_W-1:0]   s2_pix_reg;
    logic                         s2_filt_reg;
    logic                         s2_border_reg;
    logic [csea_pkg::PIX_W-1:0]   filt_pix;

    // Result queue.
    result_t                      fifo_mem [csea_pkg::FIFO_DEPTH];
    logic [csea_pkg::FPTR_W-1:0]  wr_ptr_reg;
    logic [csea_pkg::FPTR_W-1:0]  rd_ptr_reg;
    logic [csea_pkg::FCNT_W-1:0]  fifo_count_reg;
    logic                         push_filt;
    logic                         push_border;
    logic                         pop;
    logic [csea_pkg::FPTR_W-1:0]  border_slot;
    logic [csea_pkg::FCNT_W:0]    room_need;
    result_t                      filt_entry;
    result_t                      border_entry;
    result_t                      head;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= csea_pkg::RESET_FRAME_WIDTH;
            frame_height_reg   <= csea_pkg::RESET_FRAME_HEIGHT;
            edge_threshold_reg <= csea_pkg::RESET_EDGE_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                csea_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[csea_pkg::DIM_W-1:0];
                csea_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[csea_pkg::DIM_W-1:0];
                csea_pkg::REG_EDGE_THRESHOLD:
                    edge_threshold_reg <= cfg_data[csea_pkg::THR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: place the pixel in the frame
    // ------------------------------------------------------------------
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        w_eff = frame_width_reg;
        if (frame_width_reg == '0)
        begin
            w_eff = csea_pkg::DIM_W'(1);
        end
        else if (frame_width_reg > csea_pkg::MAX_WIDTH)
        begin
            w_eff = csea_pkg::DIM_W'(csea_pkg::MAX_WIDTH);
        end

        h_eff = frame_height_reg;
        if (frame_height_reg == '0)
        begin
            h_eff = csea_pkg::DIM_W'(1);
        end
        else if (frame_height_reg > csea_pkg::MAX_HEIGHT)
        begin
            h_eff = csea_pkg::DIM_W'(csea_pkg::MAX_HEIGHT);
        end

        col_start = s_tuser ? '0 : col_count_reg;
        row_start = s_tuser ? '0 : row_count_reg;
        // A counter left beyond a shrunken frame restarts at zero.
        col_cur = (csea_pkg::EXT_W'(col_start) >= csea_pkg::EXT_W'(w_eff)) ? '0 : col_start;
        row_cur = (csea_pkg::EXT_W'(row_start) >= csea_pkg::EXT_W'(h_eff)) ? '0 : row_start;

        col_last = (csea_pkg::EXT_W'(col_cur) + csea_pkg::EXT_W'(1) == csea_pkg::EXT_W'(w_eff));
        row_last = (csea_pkg::EXT_W'(row_cur) + csea_pkg::EXT_W'(1) == csea_pkg::EXT_W'(h_eff));

        small_frame = (w_eff < csea_pkg::DIM_W'(csea_pkg::MIN_SIDE))
                   || (h_eff < csea_pkg::DIM_W'(csea_pkg::MIN_SIDE));
        is_border   = small_frame || (col_cur == '0) || col_last
                   || (row_cur == '0) || row_last;
        is_interior = !small_frame && (col_cur >= csea_pkg::COL_W'(2))
                   && (row_cur >= csea_pkg::ROW_W'(2));

        if (col_last)
        begin
            col_count_next = '0;
            row_count_next = row_last ? '0 : row_cur + csea_pkg::ROW_W'(1);
        end
        else
        begin
            col_count_next = col_cur + csea_pkg::COL_W'(1);
            row_count_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= col_cur;
            s1_row_reg    <= row_cur;
            s1_pix_reg    <= s_tdata[csea_pkg::PIX_W-1:0];
            s1_filt_reg   <= is_interior;
            s1_border_reg <= is_border;
        end
    end

    // ------------------------------------------------------------------
    // Line store: word c holds column c of the even row (low half) and of
    // the odd row (high half).
    // ------------------------------------------------------------------
    csea_ram #(
        .WIDTH (2*csea_pkg::PIX_W),
        .DEPTH (csea_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (store_wdata),
        .re    (accept),
        .raddr (col_cur),
        .rdata (store_rdata)
    );

    // The item read in the cycle the previous item wrote the same word
    // (frames one pixel wide) takes the written word instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s1_col_reg;
        fwd_data_reg <= store_wdata;
    end

    always_comb
    begin
        line_word = (fwd_valid_reg && (fwd_addr_reg == s1_col_reg)) ? fwd_data_reg
                                                                    : store_rdata;
        if (s1_row_reg[0])
        begin
            east_pix    = line_word[csea_pkg::PIX_W-1:0];
            up2_pix     = line_word[2*csea_pkg::PIX_W-1:csea_pkg::PIX_W];
            store_wdata = {s1_pix_reg, east_pix};
        end
        else
        begin
            east_pix    = line_word[2*csea_pkg::PIX_W-1:csea_pkg::PIX_W];
            up2_pix     = line_word[csea_pkg::PIX_W-1:0];
            store_wdata = {east_pix, s1_pix_reg};
        end

        taps.m = above_center_reg;
        taps.n = above_north_reg;
        taps.s = left_pixel_reg;
        taps.e = east_pix;
        taps.w = above_west_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pixel_reg   <= '0;
            above_center_reg <= '0;
            above_west_reg   <= '0;
            above_north_reg  <= '0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                above_west_reg   <= above_center_reg;
                above_center_reg <= east_pix;
                above_north_reg  <= up2_pix;
                left_pixel_reg   <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_col_reg    <= s1_col_reg;
        s2_row_reg    <= s1_row_reg;
        s2_pix_reg    <= s1_pix_reg;
        s2_filt_reg   <= s1_filt_reg;
        s2_border_reg <= s1_border_reg;
    end

    csea_filter u_filter (
        .clk       (clk),
        .taps      (taps),
        .threshold (edge_threshold_reg),
        .pixel     (filt_pix)
    );

    // ------------------------------------------------------------------
    // Result queue: the interior result goes in ahead of the border result.
    // ------------------------------------------------------------------
    always_comb
    begin
        push_filt   = s2_valid_reg && s2_filt_reg;
        push_border = s2_valid_reg && s2_border_reg;
        pop         = m_tvalid && m_tready;
        border_slot = push_filt ? wr_ptr_reg + csea_pkg::FPTR_W'(1) : wr_ptr_reg;

        filt_entry.col  = s2_col_reg - csea_pkg::COL_W'(1);
        filt_entry.row  = s2_row_reg - csea_pkg::ROW_W'(1);
        filt_entry.pix  = filt_pix;
        filt_entry.last = !s2_border_reg;

        border_entry.col  = s2_col_reg;
        border_entry.row  = s2_row_reg;
        border_entry.pix  = s2_pix_reg;
        border_entry.last = 1'b1;

        // Room for the results of this item and of the two still in flight.
        room_need = (csea_pkg::FCNT_W+1)'(fifo_count_reg)
                  + (csea_pkg::FCNT_W+1)'({s1_valid_reg, 1'b0})
                  + (csea_pkg::FCNT_W+1)'({s2_valid_reg, 1'b0})
                  + (csea_pkg::FCNT_W+1)'(2);
    end

    assign s_tready = rst_n && (room_need <= (csea_pkg::FCNT_W+1)'(csea_pkg::FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push_filt)
        begin
            fifo_mem[wr_ptr_reg] <= filt_entry;
        end
        if (push_border)
        begin
            fifo_mem[border_slot] <= border_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + csea_pkg::FPTR_W'(push_filt)
                                     + csea_pkg::FPTR_W'(push_border);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + csea_pkg::FPTR_W'(1);
            end
            fifo_count_reg <= fifo_count_reg + csea_pkg::FCNT_W'(push_filt)
                                             + csea_pkg::FCNT_W'(push_border)
                                             - csea_pkg::FCNT_W'(pop);
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (fifo_count_reg != '0);
    assign m_tlast  = head.last;
    assign m_tdata  = csea_pkg::OUT_DATA_W'({head.pix, head.row, head.col});

endmodule

>>> rtl/core/csea_checker.sv
module csea_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [csea_pkg::OUT_DATA_W-1:0]      m_tdata,
    input logic                                 m_tlast
);

    logic [csea_pkg::COL_W-1:0] out_col;
    logic [csea_pkg::ROW_W-1:0] out_row;

    assign out_col = m_tdata[csea_pkg::COL_W-1:0];
    assign out_row = m_tdata[csea_pkg::COL_W +: csea_pkg::ROW_W];

    // Nothing is offered or taken while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !s_tready && !m_tvalid)
        else $error("stream handshake active during reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Filtered results never sit in the first row or column, so those are
    // always the only or the last result of their item.
    a_edge_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_col == '0 || out_row == '0) |-> m_tlast)
        else $error("first row or column result not marked last");

    // An interior result that is not last is followed at once by the border
    // pixel one row down and one column right.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast
            && out_col == $past(out_col) + csea_pkg::COL_W'(1)
            && out_row == $past(out_row) + csea_pkg::ROW_W'(1))
        else $error("border result does not follow its interior result");

endmodule

bind cross_stencil_edge_antialias csea_checker u_csea_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> bench/csea_result_check.sv
module csea_result_check (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [csea_pkg::IN_DATA_W-1:0]     s_tdata,   // pixel_in
    input  logic                               s_tuser,   // frame_start

    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [csea_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_col, out_row, pixel_out
    input  logic                               m_tlast,   // last_of_item

    input  logic                               cfg_we,
    input  logic [csea_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [csea_pkg::CFG_DATA_W-1:0]    cfg_data,

    output int                                 mismatch_count,
    output int                                 due_count
);

    import csea_pkg::*;

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } pixel_result_t;

    pixel_result_t    due_pixels [$];

    // Two rows above the current one, selected by row parity.
    logic [PIX_W-1:0] row_mem [0:2*MAX_WIDTH-1];

    // Window around the pixel one row up and one column left of the input.
    logic [PIX_W-1:0] prev_pixel;
    logic [PIX_W-1:0] centre_pixel;
    logic [PIX_W-1:0] west_pixel;
    logic [PIX_W-1:0] north_pixel;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] threshold_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;

    function automatic int unsigned side_len(input logic [DIM_W-1:0] v,
                                             input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Five-tap cross blend: average across the stronger gradient direction when
    // the widest channel spread reaches the threshold.
    function automatic logic [PIX_W-1:0] blend_cross(input logic [PIX_W-1:0] m,
                                                     input logic [PIX_W-1:0] n,
                                                     input logic [PIX_W-1:0] s,
                                                     input logic [PIX_W-1:0] e,
                                                     input logic [PIX_W-1:0] w,
                                                     input int unsigned thr);
        int unsigned      tap [5];
        int unsigned      hi;
        int unsigned      lo;
        int unsigned      spread;
        int unsigned      grad_ew;
        int unsigned      grad_ns;
        logic [PIX_W-1:0] t1;
        logic [PIX_W-1:0] t2;
        logic [PIX_W-1:0] res;
        spread  = 0;
        grad_ew = 0;
        grad_ns = 0;
        res     = '0;
        for (int ch = 0; ch < N_CHAN; ch++)
        begin
            tap[0] = m[ch*CHAN_W +: CHAN_W];
            tap[1] = n[ch*CHAN_W +: CHAN_W];
            tap[2] = s[ch*CHAN_W +: CHAN_W];
            tap[3] = e[ch*CHAN_W +: CHAN_W];
            tap[4] = w[ch*CHAN_W +: CHAN_W];
            hi = tap[0];
            lo = tap[0];
            for (int i = 1; i < 5; i++)
            begin
                if (tap[i] > hi)
                    hi = tap[i];
                if (tap[i] < lo)
                    lo = tap[i];
            end
            if (hi - lo > spread)
                spread = hi - lo;
            grad_ew += (tap[3] > tap[4]) ? tap[3] - tap[4] : tap[4] - tap[3];
            grad_ns += (tap[1] > tap[2]) ? tap[1] - tap[2] : tap[2] - tap[1];
        end
        if (spread < thr)
            return m;
        if (grad_ew >= grad_ns)
        begin
            t1 = e;
            t2 = w;
        end
        else
        begin
            t1 = n;
            t2 = s;
        end
        for (int ch = 0; ch < N_CHAN; ch++)
            res[ch*CHAN_W +: CHAN_W] = (int'(m[ch*CHAN_W +: CHAN_W])
                                       + int'(t1[ch*CHAN_W +: CHAN_W])
                                       + int'(t2[ch*CHAN_W +: CHAN_W])) / 3;
        return res;
    endfunction

    task automatic flag_field(input string field, input int unsigned want,
                              input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_result_t    got;
        pixel_result_t    want;
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] east;
        logic [PIX_W-1:0] up2;
        bit               small_frame;
        bit               inner;
        bit               border;
        if (!rst_n)
        begin
            width_reg     = RESET_FRAME_WIDTH;
            height_reg    = RESET_FRAME_HEIGHT;
            threshold_reg = RESET_EDGE_THRESHOLD;
            prev_pixel    = '0;
            centre_pixel  = '0;
            west_pixel    = '0;
            north_pixel   = '0;
            col_pos       = 0;
            row_pos       = 0;
            for (int i = 0; i < 2*MAX_WIDTH; i++)
                row_mem[i] = '0;
            due_pixels.delete();
            mismatch_count = 0;
            due_count     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:    width_reg     = cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT:   height_reg    = cfg_data[DIM_W-1:0];
                    REG_EDGE_THRESHOLD: threshold_reg = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                w   = side_len(width_reg, MAX_WIDTH);
                h   = side_len(height_reg, MAX_HEIGHT);
                pix = s_tdata[PIX_W-1:0];
                if (s_tuser)
                begin
                    col_pos = 0;
                    row_pos = 0;
                end
                // A shrunk frame can leave the position outside; it restarts.
                if (col_pos >= w)
                    col_pos = 0;
                if (row_pos >= h)
                    row_pos = 0;
                c = col_pos;
                r = row_pos;
                small_frame = (w < MIN_SIDE) || (h < MIN_SIDE);
                east   = row_mem[((r + 1) % 2) * MAX_WIDTH + c];
                up2    = row_mem[(r % 2) * MAX_WIDTH + c];
                inner  = !small_frame && c >= 2 && r >= 2;
                border = small_frame || c == 0 || c == w - 1 || r == 0 || r == h - 1;

                if (inner)
                begin
                    want.col   = COL_W'(c - 1);
                    want.row   = ROW_W'(r - 1);
                    want.pixel = blend_cross(centre_pixel, north_pixel, prev_pixel,
                                             east, west_pixel, threshold_reg);
                    want.last  = !border;
                    due_pixels.push_back(want);
                end

                west_pixel   = centre_pixel;
                centre_pixel = east;
                north_pixel  = up2;
                prev_pixel   = pix;
                row_mem[(r % 2) * MAX_WIDTH + c] = pix;

                if (border)
                begin
                    want.col   = COL_W'(c);
                    want.row   = ROW_W'(r);
                    want.pixel = pix;
                    want.last  = 1'b1;
                    due_pixels.push_back(want);
                end

                if (c + 1 >= w)
                begin
                    col_pos = 0;
                    row_pos = (r + 1 >= h) ? 0 : r + 1;
                end
                else
                    col_pos = c + 1;
            end

            if (m_tvalid && m_tready)
            begin
                got.col   = m_tdata[COL_W-1:0];
                got.row   = m_tdata[COL_W +: ROW_W];
                got.pixel = m_tdata[COL_W+ROW_W +: PIX_W];
                got.last  = m_tlast;
                if (due_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $error("unexpected result at column %0d row %0d", got.col, got.row);
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (got.col !== want.col)
                        flag_field("out_col", want.col, got.col);
                    if (got.row !== want.row)
                        flag_field("out_row", want.row, got.row);
                    if (got.pixel !== want.pixel)
                        flag_field("pixel_out", want.pixel, got.pixel);
                    if (got.last !== want.last)
                        flag_field("last_of_item", want.last, got.last);
                end
            end

            due_count <= due_pixels.size();
        end
    end

endmodule

>>> bench/tb.sv
module tb;

    import csea_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 850;
    localparam int PREFILL_W      = 16;

    logic                  clk;
    logic                  rst_n;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // pixel_in
    logic                  s_tuser;    // frame_start

    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // out_col, out_row, pixel_out
    logic                  m_tlast;    // last_of_item

    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatch_count;
    int                    due_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    quiet_cycles;
    int                    pixel_style;
    logic [PIX_W-1:0]      tone_a;
    logic [PIX_W-1:0]      tone_b;

    cross_stencil_edge_antialias dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    csea_result_check result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .due_count      (due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int unsigned frame_side(input int unsigned v, input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Hand-picked 3x3 frames: a horizontal edge, a wrap into the next frame and a
    // restart in mid-frame into a vertical edge.
    function automatic logic [PIX_W-1:0] directed_pixel(input int k);
        case (k)
            0, 1, 2:  return 24'hFFFFFF;
            4:        return 24'hFF00FF;
            9:        return 24'h00FF00;
            10:       return 24'hFFFFFF;
            11:       return 24'h0000FF;
            12:       return 24'h123456;
            13, 19:   return 24'h00FF00;
            14:       return 24'hFFFF00;
            15, 21:   return 24'hFF0000;
            17:       return 24'h808080;
            18:       return 24'hFFFFFF;
            20:       return 24'h7F7F7F;
            default:  return 24'h000000;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel();
        case (pixel_style)
            0:       return PIX_W'($urandom);
            1:       return ($urandom_range(3) == 0) ? tone_b : tone_a;
            default: return tone_a ^ PIX_W'($urandom & 32'h070707);
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned thr);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_FRAME_WIDTH;
        cfg_data <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_addr <= REG_FRAME_HEIGHT;
        cfg_data <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_addr <= REG_EDGE_THRESHOLD;
        cfg_data <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Feeds n items as back-to-back frames of fsize pixels. Without carry the first
    // item starts a frame; later ones restart or wrap, and any item may restart.
    task automatic feed_frames(input int unsigned fsize, input int unsigned n,
                               input bit carry);
        bit start;
        for (int unsigned i = 0; i < n; i++)
        begin
            start = (i == 0 && !carry)
                    || (i != 0 && i % fsize == 0 && $urandom_range(9) < 7)
                    || ($urandom_range(49) == 0);
            push_pixel(next_pixel(), start);
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned thr;
        int unsigned n;
        int unsigned fsize;
        int unsigned prev_w;
        int unsigned random_sent;
        bit          carry;

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_FRAME_WIDTH;
        cfg_data      = '0;
        quiet_cycles  = 0;
        send_idle_pct = 26;
        recv_idle_pct = 60;
        pixel_style   = 0;
        tone_a        = '0;
        tone_b        = '1;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame(3, 3, 0);
        for (int k = 0; k < 22; k++)
            push_pixel(directed_pixel(k), k == 0 || k == 13);
        settle();

        // Too narrow for any interior pixel: everything passes through.
        set_frame(2, 5, 0);
        push_pixel(24'hABCDEF, 1'b1);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'h543210, 1'b0);
        settle();

        // Fill both row parities of the narrow columns so that later phases can
        // continue a frame across a size change.
        set_frame(PREFILL_W, 3, $urandom_range(0, 80));
        feed_frames(PREFILL_W * 3, PREFILL_W * 3, 1'b0);
        random_sent = PREFILL_W * 3;
        prev_w      = PREFILL_W;

        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (random_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (random_sent >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 26;
            end

            case ($urandom_range(19))
                0:       w = 1;
                1:       w = 2;
                2:       w = 0;
                3:       w = 4095;
                4:       w = MAX_WIDTH;
                5:       w = $urandom_range(17, 40);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(19))
                0:       h = 1;
                1:       h = 2;
                2:       h = 0;
                3:       h = 4095;
                4:       h = MAX_HEIGHT;
                default: h = $urandom_range(3, 8);
            endcase
            case ($urandom_range(7))
                0:       thr = 0;
                1:       thr = 256;
                2:       thr = 511;
                3:       thr = 255;
                4:       thr = $urandom_range(0, 511);
                default: thr = $urandom_range(1, 90);
            endcase

            pixel_style = $urandom_range(2);
            tone_a      = PIX_W'($urandom);
            tone_b      = ($urandom_range(1) == 0) ? ~tone_a : PIX_W'($urandom);
            if ($urandom_range(3) == 0)
            begin
                tone_a = '0;
                tone_b = '1;
            end

            // Continuing the old frame stays within columns that are already written.
            carry = frame_side(w, MAX_WIDTH) <= PREFILL_W && prev_w <= PREFILL_W
                    && $urandom_range(3) == 0;
            fsize = frame_side(w, MAX_WIDTH) * frame_side(h, MAX_HEIGHT);
            n = fsize * $urandom_range(1, 3);
            if (n > 60)
                n = $urandom_range(20, 60);
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, n);

            set_frame(w, h, thr);
            feed_frames(fsize, n, carry);
            random_sent += n;
            prev_w = frame_side(w, MAX_WIDTH);
        end
        settle();

        // One full-width row and one full-height column reach the largest
        // coordinates, and each ends by wrapping to the first pixel.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pixel_style   = 0;
        set_frame(4095, 1, 0);
        for (int i = 0; i <= MAX_WIDTH; i++)
            push_pixel(next_pixel(), i == 0);
        settle();
        set_frame(0, 4095, 0);
        for (int i = 0; i <= MAX_HEIGHT; i++)
            push_pixel(next_pixel(), i == 0);
        settle();

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
